// ----- sv/uprox_pkg.sv -----
// ----------------------------------------------------------------------------
// uprox_pkg: shared types and constants for the proximity reporter
// Event kinds, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package uprox_pkg;

    // Field widths
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PERIOD_W   = 10;
    localparam int unsigned LOCKOUT_W  = 16;
    localparam int unsigned NEAR_W     = 24;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MIN_W      = 6;
    localparam int unsigned SEC_W      = 6;
    localparam int unsigned RUN_MIN_W  = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned FUNC_W     = 2;

    // Stream packing
    localparam int unsigned S_TDATA_W = 40;  // level + edge time, padded to bytes
    localparam int unsigned M_TDATA_W = 72;  // 71 bits of result fields, padded

    // Event kinds carried in s_tuser; code 3 means nothing
    typedef enum logic [FUNC_W-1:0] {
        FUNC_MS_TICK   = 2'd0,
        FUNC_SEC_TICK  = 2'd1,
        FUNC_ECHO_EDGE = 2'd2
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PERIOD_MS    = 3'd0,
        REG_LOCKOUT_MS   = 3'd1,
        REG_NEAR_WIDTH   = 3'd2,
        REG_START_HOUR   = 3'd3,
        REG_START_MINUTE = 3'd4,
        REG_START_SECOND = 3'd5
    } cfg_reg_t;

    // Reset values
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd60;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = 16'd7000;
    localparam logic [NEAR_W-1:0]    NEAR_RST    = 24'd487200;
    localparam logic [HOUR_W-1:0]    HOUR_RST    = 5'd9;
    localparam logic [MIN_W-1:0]     MIN_RST     = 6'd7;
    localparam logic [SEC_W-1:0]     SEC_RST     = 6'd17;

    // Time-of-day limits
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;

endpackage

// ----- sv/ultrasonic_proximity_reporter.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_proximity_reporter: echo timer with near-object report
// Times echo pulses, keeps a time of day and run time, and emits one
// trigger result per measurement period.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, then the result register, before
//   its result shows on m_tdata; a full result register can hold it in between.
// Throughput: one request per cycle; the only stall is a finished result
//   still waiting in the result register while another one is due.
// Reset: synchronous, active low; clears all counters and flags, loads the
//   configuration defaults and sets the time of day to 09:07:17.
module ultrasonic_proximity_reporter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [uprox_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uprox_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [uprox_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] echo_level, [32:1] edge_time
    input  logic [uprox_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [uprox_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] pulse_width,
                                                         // [36:32] clock_hour,
                                                         // [42:37] clock_minute,
                                                         // [48:43] clock_second,
                                                         // [64:49] run_minutes,
                                                         // [70:65] run_seconds
    output logic                              m_tuser    // [0] report
);
    import uprox_pkg::*;

    // ---------------- configuration ----------------
    // The start-of-day values are fixed by the reset constants that load the time
    // of day, so a written value never reaches the clock; writes to them are taken
    // and dropped.
    logic [PERIOD_W-1:0]  period_reg;
    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [NEAR_W-1:0]    near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RST;
            lockout_reg <= LOCKOUT_RST;
            near_reg    <= NEAR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PERIOD_MS:    period_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_LOCKOUT_MS:   lockout_reg <= cfg_wdata[LOCKOUT_W-1:0];
                REG_NEAR_WIDTH:   near_reg    <= cfg_wdata[NEAR_W-1:0];
                REG_START_HOUR,
                REG_START_MINUTE,
                REG_START_SECOND: ;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic              in_valid_reg;
    logic [FUNC_W-1:0] in_func_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_time_reg;

    // ---------------- block state ----------------
    logic [TIME_W-1:0]    ms_now_reg;
    logic [TIME_W-1:0]    last_trig_reg;
    logic [TIME_W-1:0]    last_rpt_reg;
    logic [TIME_W-1:0]    rise_time_reg;
    logic [TIME_W-1:0]    width_reg;
    logic                 smp_valid_reg;
    logic                 smp_ready_reg;
    logic [HOUR_W-1:0]    tod_hour_reg;
    logic [MIN_W-1:0]     tod_min_reg;
    logic [SEC_W-1:0]     tod_sec_reg;
    logic [RUN_MIN_W-1:0] run_min_reg;
    logic [SEC_W-1:0]     run_sec_reg;

    // ---------------- result register ----------------
    logic                 m_valid_reg;
    logic                 m_report_reg;
    logic [TIME_W-1:0]    m_width_reg;
    logic [HOUR_W-1:0]    m_hour_reg;
    logic [MIN_W-1:0]     m_min_reg;
    logic [SEC_W-1:0]     m_sec_reg;
    logic [RUN_MIN_W-1:0] m_run_min_reg;
    logic [SEC_W-1:0]     m_run_sec_reg;

    // ---------------- processing stage ----------------
    logic              out_free;
    logic [TIME_W-1:0] ms_inc;
    logic              period_due;
    logic              fire;
    logic              stage_go;
    logic              near_hit;
    logic              lockout_done;
    logic              report;

    assign out_free     = !m_valid_reg || m_tready;
    assign ms_inc       = ms_now_reg + TIME_W'(1);
    // modular 32-bit elapsed-time tests
    assign period_due   = (ms_inc - last_trig_reg) >= TIME_W'(period_reg);
    assign lockout_done = (ms_inc - last_rpt_reg) >= TIME_W'(lockout_reg);
    assign near_hit     = smp_ready_reg && smp_valid_reg && (width_reg < TIME_W'(near_reg));
    assign report       = near_hit && lockout_done;

    // only a due trigger needs room in the result register
    assign fire     = in_valid_reg && (in_func_reg == FUNC_MS_TICK) && period_due;
    assign stage_go = in_valid_reg && (!fire || out_free);
    assign s_tready = !in_valid_reg || stage_go;

    // second tick: each unit counts at full width and wraps on reaching its limit
    logic [SEC_W:0]     sec_inc, run_sec_inc;
    logic [MIN_W:0]     min_inc;
    logic [HOUR_W:0]    hour_inc;
    logic               sec_wrap, min_wrap, hour_wrap, run_sec_wrap;

    always_comb begin
        sec_inc      = {1'b0, tod_sec_reg} + (SEC_W+1)'(1);
        min_inc      = {1'b0, tod_min_reg} + (MIN_W+1)'(1);
        hour_inc     = {1'b0, tod_hour_reg} + (HOUR_W+1)'(1);
        run_sec_inc  = {1'b0, run_sec_reg} + (SEC_W+1)'(1);
        sec_wrap     = sec_inc >= (SEC_W+1)'(SEC_PER_MIN);
        min_wrap     = min_inc >= (MIN_W+1)'(MIN_PER_HOUR);
        hour_wrap    = hour_inc >= (HOUR_W+1)'(HOUR_PER_DAY);
        run_sec_wrap = run_sec_inc >= (SEC_W+1)'(SEC_PER_MIN);
    end

    // input register: payload without reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg  <= s_tuser;
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[TIME_W:1];
        end
    end

    // state update, one request per cycle unless a due trigger finds the result register full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_now_reg    <= '0;
            last_trig_reg <= '0;
            last_rpt_reg  <= '0;
            rise_time_reg <= '0;
            width_reg     <= '0;
            smp_valid_reg <= 1'b0;
            smp_ready_reg <= 1'b0;
            tod_hour_reg  <= HOUR_RST;
            tod_min_reg   <= MIN_RST;
            tod_sec_reg   <= SEC_RST;
            run_min_reg   <= '0;
            run_sec_reg   <= '0;
        end else if (stage_go) begin
            unique case (in_func_reg)
                FUNC_MS_TICK: begin
                    ms_now_reg <= ms_inc;
                    if (period_due) begin
                        last_trig_reg <= ms_inc;
                        smp_ready_reg <= 1'b0;   // re-arm measurement
                        if (report) begin
                            last_rpt_reg <= ms_inc;
                        end
                    end
                end
                FUNC_SEC_TICK: begin
                    if (run_sec_wrap) begin
                        run_sec_reg <= '0;
                        run_min_reg <= run_min_reg + RUN_MIN_W'(1);
                    end else begin
                        run_sec_reg <= run_sec_inc[SEC_W-1:0];
                    end
                    if (sec_wrap) begin
                        tod_sec_reg <= '0;
                        if (min_wrap) begin
                            tod_min_reg <= '0;
                            tod_hour_reg <= hour_wrap ? '0 : hour_inc[HOUR_W-1:0];
                        end else begin
                            tod_min_reg <= min_inc[MIN_W-1:0];
                        end
                    end else begin
                        tod_sec_reg <= sec_inc[SEC_W-1:0];
                    end
                end
                FUNC_ECHO_EDGE: begin
                    if (in_level_reg) begin
                        rise_time_reg <= in_time_reg;
                    end else begin
                        // end not later than start (wrap included): invalid
                        if (in_time_reg > rise_time_reg) begin
                            width_reg     <= in_time_reg - rise_time_reg;
                            smp_valid_reg <= 1'b1;
                        end else begin
                            smp_valid_reg <= 1'b0;
                        end
                        smp_ready_reg <= 1'b1;
                    end
                end
                default: ;   // unused kind is dropped
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && stage_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && stage_go) begin
            m_report_reg  <= report;
            m_width_reg   <= width_reg;
            m_hour_reg    <= tod_hour_reg;
            m_min_reg     <= tod_min_reg;
            m_sec_reg     <= tod_sec_reg;
            m_run_min_reg <= run_min_reg;
            m_run_sec_reg <= run_sec_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_report_reg;
    assign m_tdata  = {1'b0, m_run_sec_reg, m_run_min_reg, m_sec_reg, m_min_reg,
                       m_hour_reg, m_width_reg};

endmodule

// ----- sv/uprox_checker.sv -----
// ----------------------------------------------------------------------------
// uprox_checker: port-level checks for the proximity reporter
// Watches the result stream over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module uprox_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [uprox_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import uprox_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // clock fields stay within their limits
    a_clock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:32] < 5'd24) && (m_tdata[42:37] < 6'd60) &&
                     (m_tdata[48:43] < 6'd60) && (m_tdata[70:65] < 6'd60))
        else $error("time field out of range");

    // a report needs a valid echo, whose width is never zero
    a_report_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0)
        else $error("report with zero pulse width");

endmodule

bind ultrasonic_proximity_reporter uprox_checker u_uprox_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ultrasonic_proximity_reporter
// Drives tick and echo-edge requests on the input stream and writes the
// config registers between phases. A scoreboard class tracks the echo,
// clock and lockout state and holds the trigger results still due. Every
// result taken from the output stream is checked field by field against
// the oldest one. Both stream sides idle in random bursts; one long
// receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import uprox_pkg::*;

    // s_tuser code that the block ignores
    localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;

    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_PAUSE = 6;     // block latency plus margin
    localparam int ROLL_TICKS  = 100;   // requests in the clock roll, mostly second ticks, enough to wrap the minute

    // One trigger result as it should leave the block
    typedef struct {
        bit        report;
        bit [31:0] pulse_width;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit [15:0] run_minutes;
        bit [5:0]  run_seconds;
    } trigger_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the reporter state and the triggers still due
    // ------------------------------------------------------------------------
    class trigger_scoreboard;
        bit [PERIOD_W-1:0]  period_ms;
        bit [LOCKOUT_W-1:0] lockout_ms;
        bit [NEAR_W-1:0]    near_width;
        bit [HOUR_W-1:0]    start_hour;
        bit [MIN_W-1:0]     start_minute;
        bit [SEC_W-1:0]     start_second;

        bit [31:0]          ms_now;
        bit [31:0]          last_trigger_ms;
        bit [31:0]          last_report_ms;
        bit [31:0]          rise_stamp;
        bit [31:0]          pulse_len;
        bit                 sample_valid;
        bit                 sample_ready;
        bit [HOUR_W-1:0]    tod_hour;
        bit [MIN_W-1:0]     tod_minute;
        bit [SEC_W-1:0]     tod_second;
        bit [RUN_MIN_W-1:0] run_min;
        bit [SEC_W-1:0]     run_sec;

        trigger_t           due_triggers[$];
        int                 mismatches;

        function void reset_state();
            period_ms       = PERIOD_RST;
            lockout_ms      = LOCKOUT_RST;
            near_width      = NEAR_RST;
            start_hour      = HOUR_RST;
            start_minute    = MIN_RST;
            start_second    = SEC_RST;
            ms_now          = '0;
            last_trigger_ms = '0;
            last_report_ms  = '0;
            rise_stamp      = '0;
            pulse_len       = '0;
            sample_valid    = 1'b0;
            sample_ready    = 1'b0;
            tod_hour        = start_hour;
            tod_minute      = start_minute;
            tod_second      = start_second;
            run_min         = '0;
            run_sec         = '0;
            due_triggers.delete();
            mismatches      = 0;
        endfunction

        // start values only matter at reset, which never comes again
        function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PERIOD_MS:    period_ms    = value[PERIOD_W-1:0];
                REG_LOCKOUT_MS:   lockout_ms   = value[LOCKOUT_W-1:0];
                REG_NEAR_WIDTH:   near_width   = value[NEAR_W-1:0];
                REG_START_HOUR:   start_hour   = value[HOUR_W-1:0];
                REG_START_MINUTE: start_minute = value[MIN_W-1:0];
                REG_START_SECOND: start_second = value[SEC_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted request; queue the trigger it causes, if any
        function void note_request(bit [FUNC_W-1:0] func, bit level, bit [31:0] stamp);
            trigger_t trig;
            case (func)
                FUNC_SEC_TICK: begin
                    run_sec = run_sec + 1'b1;
                    if (run_sec >= SEC_PER_MIN) begin
                        run_sec = '0;
                        run_min = run_min + 1'b1;
                    end
                    tod_second = tod_second + 1'b1;
                    if (tod_second >= SEC_PER_MIN) begin
                        tod_second = '0;
                        tod_minute = tod_minute + 1'b1;
                        if (tod_minute >= MIN_PER_HOUR) begin
                            tod_minute = '0;
                            tod_hour   = tod_hour + 1'b1;
                            if (tod_hour >= HOUR_PER_DAY)
                                tod_hour = '0;
                        end
                    end
                end
                FUNC_ECHO_EDGE: begin
                    if (level) begin
                        rise_stamp = stamp;
                    end else begin
                        // end not later than start (wrap included): keep old width
                        if (stamp > rise_stamp) begin
                            pulse_len    = stamp - rise_stamp;
                            sample_valid = 1'b1;
                        end else begin
                            sample_valid = 1'b0;
                        end
                        sample_ready = 1'b1;
                    end
                end
                FUNC_MS_TICK: begin
                    ms_now = ms_now + 1;
                    if (ms_now - last_trigger_ms >= period_ms) begin
                        last_trigger_ms = ms_now;
                        trig.report = 1'b0;
                        if (sample_ready && sample_valid && pulse_len < near_width &&
                            ms_now - last_report_ms >= lockout_ms) begin
                            last_report_ms = ms_now;
                            trig.report    = 1'b1;
                        end
                        sample_ready     = 1'b0;
                        trig.pulse_width = pulse_len;
                        trig.hour        = tod_hour;
                        trig.minute      = tod_minute;
                        trig.second      = tod_second;
                        trig.run_minutes = run_min;
                        trig.run_seconds = run_sec;
                        due_triggers.push_back(trig);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0d (0x%h), got %0d (0x%h)",
                             name, want, want, got, got);
            end
        endfunction

        function void check_result(logic report, logic [M_TDATA_W-1:0] data);
            trigger_t want;
            if (due_triggers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing due: report %b, data 0x%h", report, data);
                return;
            end
            want = due_triggers.pop_front();
            check_field("report",       want.report,      report);
            check_field("pulse_width",  want.pulse_width, data[31:0]);
            check_field("clock_hour",   want.hour,        data[36:32]);
            check_field("clock_minute", want.minute,      data[42:37]);
            check_field("clock_second", want.second,      data[48:43]);
            check_field("run_minutes",  want.run_minutes, data[64:49]);
            check_field("run_seconds",  want.run_seconds, data[70:65]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [0] echo_level, [32:1] edge_time
    logic [FUNC_W-1:0]     s_tuser;   // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [31:0] pulse_width, [36:32] clock_hour,
                                      // [42:37] clock_minute, [48:43] clock_second,
                                      // [64:49] run_minutes, [70:65] run_seconds
    logic                  m_tuser;   // [0] report

    trigger_scoreboard sb;

    // Idle control shared between the stimulus and the receiver
    bit src_idling   = 1'b1;
    bit sink_idling  = 1'b1;
    bit hold_request = 1'b0;
    int stuck_cycles = 0;

    ultrasonic_proximity_reporter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off on demand.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int idle_left;
        bit hold_taken;
        hold_left  = 0;
        idle_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else if (sink_idling && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor: every accepted result goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Watchdog: ends the run if neither side moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL ultrasonic_proximity_reporter");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks: entered and left just after a falling edge
    // ------------------------------------------------------------------------
    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        sb.write_reg(idx, CFG_DATA_W'(value));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // One request; an optional idle burst first, then hold until accepted
    task automatic send_request(logic [FUNC_W-1:0] func, logic level, logic [31:0] stamp);
        int gap;
        if (src_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, stamp, level};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, level, stamp);
        @(negedge aclk);
    endtask

    // Stop sending, let every due trigger come out, then cover the latency
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.due_triggers.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    // Random traffic, mostly echo pulses and ticks; ignored codes are not counted
    task automatic run_traffic(int n_items);
        int        sent;
        int        pick;
        bit [31:0] rise;
        bit [31:0] width;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_request(FUNC_MS_TICK, 1'($urandom), $urandom);
                sent++;
            end else if (pick < 55) begin
                send_request(FUNC_SEC_TICK, 1'($urandom), $urandom);
                sent++;
            end else if (pick < 85) begin
                // full pulse: rise, then fall after a chosen width
                rise = $urandom;
                case ($urandom_range(0, 5))
                    0: width = $urandom_range(1, 1000);
                    1: width = $urandom % sb.near_width;            // near, or zero
                    2: width = sb.near_width + $urandom_range(0, 2) - 1;  // threshold
                    3: width = $urandom;                            // anything, may wrap
                    4: width = '0;                                  // fall at rise time
                    default: width = 32'd0 - $urandom_range(1, 1000);    // fall before rise
                endcase
                send_request(FUNC_ECHO_EDGE, 1'b1, rise);
                send_request(FUNC_ECHO_EDGE, 1'b0, rise + width);
                sent += 2;
            end else if (pick < 95) begin
                // lone edge: repeated rise or fall against an old start
                send_request(FUNC_ECHO_EDGE, 1'($urandom), $urandom);
                sent++;
            end else begin
                send_request(FUNC_IGNORED, 1'($urandom), $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        sb = new();
        sb.reset_state();

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: trigger every ms, no lockout, default near threshold
        write_reg(REG_PERIOD_MS, 1);
        write_reg(REG_LOCKOUT_MS, 0);
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);              // nothing measured yet
        send_request(FUNC_IGNORED, 1'b1, 32'hFFFF_FFFF);      // unused kind, no effect
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'h0);            // end equals start: invalid
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'hFFFF_FFFF);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'h5);            // counter wrapped: invalid
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'd100);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'd100 + NEAR_RST - 1);  // just below near
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);              // report
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);              // ready flag was cleared
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'(NEAR_RST));    // exactly near: no report
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'h1);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'hFFFF_FFFF);    // one short of the widest pulse
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        send_request(FUNC_SEC_TICK, 1'b1, 32'hFFFF_FFFF);
        send_request(FUNC_SEC_TICK, 1'b0, 32'h0);
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'd7);
        send_request(FUNC_ECHO_EDGE, 1'b1, 32'd10);           // second rise overwrites
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'd12);
        send_request(FUNC_ECHO_EDGE, 1'b0, 32'd20);           // measured from latest rise
        send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        wait_idle();

        // Zero period: a trigger on every ms tick
        write_reg(REG_PERIOD_MS, 0);
        repeat (3) send_request(FUNC_MS_TICK, 1'b0, 32'h0);
        wait_idle();

        // Reset defaults again: sparse triggers, long lockout
        write_reg(REG_PERIOD_MS, 32'(PERIOD_RST));
        write_reg(REG_LOCKOUT_MS, 32'(LOCKOUT_RST));
        write_reg(REG_NEAR_WIDTH, 32'(NEAR_RST));
        run_traffic(60);
        wait_idle();

        // Widest near threshold, a trigger per tick
        write_reg(REG_PERIOD_MS, 1);
        write_reg(REG_LOCKOUT_MS, 0);
        write_reg(REG_NEAR_WIDTH, 32'hFF_FFFF);
        run_traffic(110);
        wait_idle();

        // Backpressure: receiver holds off while ticks keep coming
        write_reg(REG_LOCKOUT_MS, 3);
        src_idling   = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_request(FUNC_MS_TICK, 1'b0, $urandom);
        src_idling   = 1'b1;
        wait_idle();

        // Threshold of one: nothing can count as near
        write_reg(REG_PERIOD_MS, 3);
        write_reg(REG_LOCKOUT_MS, 5);
        write_reg(REG_NEAR_WIDTH, 1);
        run_traffic(60);
        wait_idle();

        // Long period and longest lockout
        write_reg(REG_PERIOD_MS, 1000);
        write_reg(REG_LOCKOUT_MS, 32'hFFFF);
        write_reg(REG_NEAR_WIDTH, $urandom_range(1000, 1000000));
        write_reg(REG_START_HOUR, 23);
        write_reg(REG_START_MINUTE, 59);
        write_reg(REG_START_SECOND, 59);
        run_traffic(50);
        wait_idle();

        // Run the clocks across minute boundaries, sampling them now and then
        write_reg(REG_PERIOD_MS, 1);
        src_idling = 1'b0;
        for (int i = 0; i < ROLL_TICKS; i++) begin
            if (i % 20 == 0)
                send_request(FUNC_MS_TICK, 1'b0, 32'h0);
            else
                send_request(FUNC_SEC_TICK, 1'b0, 32'h0);
        end
        src_idling = 1'b1;
        wait_idle();

        write_reg(REG_PERIOD_MS, 2);
        write_reg(REG_LOCKOUT_MS, 20);
        write_reg(REG_NEAR_WIDTH, $urandom_range(1, 32'hFF_FFFF));
        write_reg(REG_START_HOUR, 0);
        write_reg(REG_START_MINUTE, 0);
        write_reg(REG_START_SECOND, 0);
        run_traffic(110);
        wait_idle();

        // Final stretch at full rate on both sides
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        write_reg(REG_PERIOD_MS, $urandom_range(1, 6));
        write_reg(REG_LOCKOUT_MS, $urandom_range(0, 30));
        write_reg(REG_NEAR_WIDTH, $urandom_range(1, 32'hFF_FFFF));
        run_traffic(110);
        wait_idle();

        if (sb.mismatches == 0 && sb.due_triggers.size() == 0)
            $display("PASS ultrasonic_proximity_reporter");
        else
            $display("FAIL ultrasonic_proximity_reporter");
        $finish;
    end

endmodule
